[rtl/core/cfsh_pkg.sv]
// Shared constants and types for the case-folding string hash.
`timescale 1ns / 1ps

package cfsh_pkg;

    // Hash constants
    localparam logic [31:0] GOLDEN     = 32'h9e37_79b9;
    localparam logic [31:0] SEED_RESET = 32'h0000_0805;

    // Bytes per block, queue depth and mix length
    localparam int BLOCK_BYTES = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int MIX_STEPS   = 9;
    localparam int STEP_W      = $clog2(MIX_STEPS);

    // One job from the front to the back: word adds plus control
    typedef struct packed {
        logic [31:0] add_a;
        logic [31:0] add_b;
        logic [31:0] add_c;
        logic [31:0] len;    // string length, used on the final job
        logic [31:0] seed;   // initial c word, used on the first job
        logic        blk;    // a full block is carried
        logic        fin;    // last item of the string
        logic        first;  // first job of the string
    } t_job;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_LEN,
        BK_EMIT
    } t_back_state;

endpackage

[rtl/core/cfsh_front.sv]
// Front end: case folding, block gathering, length count and job build.
`timescale 1ns / 1ps

module cfsh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_seed_we,
    input  logic [31:0]       i_seed_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_byte_present,
    input  logic              i_is_last,
    input  logic              i_full,
    output logic              o_push,
    output cfsh_pkg::t_job    o_job
);
    import cfsh_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] r_str_seed;
    logic [7:0]  r_bytes [BLOCK_BYTES];
    logic [3:0]  r_fill;
    logic [31:0] r_len;
    logic        r_started;
    logic        r_job_sent;

    logic [7:0]  ch;
    logic [7:0]  merged [BLOCK_BYTES];
    logic [7:0]  masked [BLOCK_BYTES];
    logic        blk;
    logic [3:0]  cnt;
    logic [31:0] n_len;
    logic        accept;

    // Fold A..Z to a..z
    always_comb begin
        if (i_data_byte >= 8'h41 && i_data_byte <= 8'h5a) begin
            ch = i_data_byte + 8'h20;
        end else begin
            ch = i_data_byte;
        end
    end

    // Block complete on the twelfth byte
    assign blk    = i_byte_present && (r_fill == 4'(BLOCK_BYTES - 1));
    assign cnt    = blk ? 4'(BLOCK_BYTES) : (r_fill + 4'(i_byte_present));
    assign n_len  = r_len + 32'(i_byte_present);
    assign accept = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && (blk || i_is_last);

    // Current byte merged into the block, bytes past the count zeroed
    always_comb begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            merged[i] = (i_byte_present && r_fill == 4'(i)) ? ch : r_bytes[i];
            masked[i] = (4'(i) < cnt) ? merged[i] : 8'h00;
        end
    end

    // Job word: full block little-endian, or tail with c's low byte left free
    always_comb begin
        o_job.add_a = {masked[3], masked[2], masked[1], masked[0]};
        o_job.add_b = {masked[7], masked[6], masked[5], masked[4]};
        if (blk) begin
            o_job.add_c = {masked[11], masked[10], masked[9], masked[8]};
        end else begin
            o_job.add_c = {masked[10], masked[9], masked[8], 8'h00};
        end
        o_job.len   = n_len;
        o_job.seed  = r_started ? r_str_seed : r_seed;
        o_job.blk   = blk;
        o_job.fin   = i_is_last;
        o_job.first = !r_job_sent;
    end

    // Byte store
    always_ff @(posedge i_clk) begin
        if (accept && i_byte_present) begin
            r_bytes[r_fill] <= ch;
        end
    end

    // Seed register and string control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= SEED_RESET;
            r_fill     <= '0;
            r_len      <= '0;
            r_started  <= 1'b0;
            r_job_sent <= 1'b0;
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
            if (accept) begin
                if (i_is_last) begin
                    r_fill     <= '0;
                    r_len      <= '0;
                    r_started  <= 1'b0;
                    r_job_sent <= 1'b0;
                end else if (i_byte_present) begin
                    r_fill    <= blk ? 4'd0 : r_fill + 4'd1;
                    r_len     <= n_len;
                    r_started <= 1'b1;
                    if (blk) begin
                        r_job_sent <= 1'b1;
                    end
                end
            end
        end
    end

    // Seed latched at the first byte of a string
    always_ff @(posedge i_clk) begin
        if (accept && i_byte_present && !r_started) begin
            r_str_seed <= r_seed;
        end
    end

endmodule

[rtl/core/cfsh_queue.sv]
// Short job queue between the front end and the mixing back end.
`timescale 1ns / 1ps

module cfsh_queue #(
    parameter int DEPTH = cfsh_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cfsh_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output cfsh_pkg::t_job    o_job
);
    import cfsh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/cfsh_back.sv]
// Back end: word adds, nine-step mix sequencer and hash output register.
`timescale 1ns / 1ps

module cfsh_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  cfsh_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_hash_value
);
    import cfsh_pkg::*;

    t_back_state       r_state;
    t_back_state       n_state;
    logic [STEP_W-1:0] r_step;
    logic [31:0]       r_a;
    logic [31:0]       r_b;
    logic [31:0]       r_c;
    logic [31:0]       r_len;
    logic              r_fin;
    logic              r_two;
    logic              r_out_valid;
    logic [31:0]       r_hash;

    logic [31:0]       base_a;
    logic [31:0]       base_b;
    logic [31:0]       base_c;
    logic [31:0]       mix_a;
    logic [31:0]       mix_b;
    logic [31:0]       mix_c;
    logic              out_free;
    logic              last_step;
    logic              emit;

    assign out_free  = !r_out_valid || !i_stall;
    assign last_step = (r_step == STEP_W'(MIX_STEPS - 1));

    // Starting words: fresh string or carried state
    assign base_a = i_job.first ? GOLDEN : r_a;
    assign base_b = i_job.first ? GOLDEN : r_b;
    assign base_c = i_job.first ? i_job.seed : r_c;

    // One mix step per cycle: subtract, subtract, xor with shifted word
    always_comb begin
        mix_a = r_a;
        mix_b = r_b;
        mix_c = r_c;
        unique case (r_step)
            4'd0:    mix_a = (r_a - r_b - r_c) ^ (r_c >> 13);
            4'd1:    mix_b = (r_b - r_c - r_a) ^ (r_a << 8);
            4'd2:    mix_c = (r_c - r_a - r_b) ^ (r_b >> 13);
            4'd3:    mix_a = (r_a - r_b - r_c) ^ (r_c >> 12);
            4'd4:    mix_b = (r_b - r_c - r_a) ^ (r_a << 16);
            4'd5:    mix_c = (r_c - r_a - r_b) ^ (r_b >> 5);
            4'd6:    mix_a = (r_a - r_b - r_c) ^ (r_c >> 3);
            4'd7:    mix_b = (r_b - r_c - r_a) ^ (r_a << 10);
            4'd8:    mix_c = (r_c - r_a - r_b) ^ (r_b >> 15);
            default: mix_a = r_a;
        endcase
    end

    // Next state and handshake
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        emit    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_MIX;
                end
            end
            BK_MIX: begin
                if (last_step) begin
                    if (r_two) begin
                        n_state = BK_LEN;
                    end else if (r_fin) begin
                        n_state = BK_EMIT;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_LEN: begin
                n_state = BK_MIX;
            end
            BK_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working words and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_fin  <= 1'b0;
            r_two  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_a    <= base_a + i_job.add_a;
                r_b    <= base_b + i_job.add_b;
                r_c    <= base_c + i_job.add_c + (i_job.blk ? 32'd0 : i_job.len);
                r_len  <= i_job.len;
                r_fin  <= i_job.fin;
                r_two  <= i_job.blk && i_job.fin;
                r_step <= '0;
            end else if (r_state == BK_MIX) begin
                r_a    <= mix_a;
                r_b    <= mix_b;
                r_c    <= mix_c;
                r_step <= last_step ? '0 : r_step + STEP_W'(1);
            end else if (r_state == BK_LEN) begin
                r_c   <= r_c + r_len;
                r_two <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_hash <= r_c;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_hash;

endmodule

[rtl/core/case_folding_string_hash.sv]
// Top level of the case-folding string hash: front end, job queue, back end.
//
//   channel  dir  handshake          word
//   input    in   i_valid/o_stall    i_data_byte, i_byte_present, i_is_last
//   output   out  o_valid/i_stall    o_hash_value
//   seed     in   i_seed_we          i_seed_wdata
//
// One word is taken per cycle while the job queue has room; a full queue stalls
// every input word. A full block or a last item becomes a job: the back end loads
// it and runs the mix steps (and, when a last item also completes a block, adds
// the length and runs them again), then writes the hash into the output register
// once that register is free. The back end takes a new job only when it is idle,
// so a full queue leaves the input paced by the back end.
// Reset is synchronous, active low; seed resets to 0x805.
`timescale 1ns / 1ps

module case_folding_string_hash #(
    parameter int QUEUE_DEPTH = cfsh_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_hash_value
);
    import cfsh_pkg::*;

    t_job q_in;
    t_job q_out;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    cfsh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_wdata   (i_seed_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_is_last      (i_is_last),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_job          (q_in)
    );

    cfsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out)
    );

    cfsh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_out),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

[bench/testbench.sv]
// Self-checking bench for the case-folding string hash, with a scoreboard class.
`timescale 1ns / 1ps

// Predicts the hash of each string from accepted words and checks emitted hashes
class hash_scoreboard;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    bit [31:0] seed_reg;
    bit [31:0] acc_a;
    bit [31:0] acc_b;
    bit [31:0] acc_c;
    bit [31:0] byte_count;
    bit [7:0]  block_buf [cfsh_pkg::BLOCK_BYTES];
    int        fill;
    bit        in_string;
    bit [31:0] pending_hashes [$];
    int        errors;

    function new();
        seed_reg = cfsh_pkg::SEED_RESET;
        errors   = 0;
        foreach (block_buf[i]) block_buf[i] = 8'h00;
        restart();
    endfunction

    // Fresh accumulators for the next string
    function void restart();
        acc_a      = cfsh_pkg::GOLDEN;
        acc_b      = cfsh_pkg::GOLDEN;
        acc_c      = seed_reg;
        fill       = 0;
        byte_count = 0;
        in_string  = 1'b0;
    endfunction

    // Nine-step subtract/xor/shift mix
    function void mix_words();
        bit [31:0] a;
        bit [31:0] b;
        bit [31:0] c;
        a = acc_a;
        b = acc_b;
        c = acc_c;
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        acc_a = a;
        acc_b = b;
        acc_c = c;
    endfunction

    function bit [31:0] le_word(int base);
        return {block_buf[base + 3], block_buf[base + 2], block_buf[base + 1], block_buf[base]};
    endfunction

    // A seed write reloads c only if the current string has no byte yet
    function void load_seed(bit [31:0] value);
        seed_reg = value;
        if (!in_string) acc_c = value;
    endfunction

    // Accepted input word
    function void note_item(bit [7:0] raw, bit present, bit is_end);
        bit [7:0]  ch;
        bit [31:0] v;
        if (present) begin
            ch = raw;
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ch = ch + CASE_BIT;
            if (fill >= cfsh_pkg::BLOCK_BYTES) fill = 0;
            block_buf[fill] = ch;
            fill++;
            byte_count++;
            in_string = 1'b1;
            if (fill == cfsh_pkg::BLOCK_BYTES) begin
                acc_a += le_word(0);
                acc_b += le_word(4);
                acc_c += le_word(8);
                mix_words();
                fill = 0;
            end
        end
        if (is_end) begin
            // Tail layout: c's low byte is kept for the length
            acc_c += byte_count;
            for (int i = 0; i < fill; i++) begin
                v = {24'h0, block_buf[i]};
                if (i < 4) acc_a += v << (8 * i);
                else if (i < 8) acc_b += v << (8 * (i - 4));
                else acc_c += v << (8 * (i - 7));
            end
            mix_words();
            pending_hashes.push_back(acc_c);
            restart();
        end
    endfunction

    // Accepted output word
    function void check_hash(bit [31:0] got);
        bit [31:0] want;
        if (pending_hashes.size() == 0) begin
            $display("%0t: unexpected hash: expected none, actual %08h", $time, got);
            errors++;
        end else begin
            want = pending_hashes.pop_front();
            if (got !== want) begin
                $display("%0t: hash mismatch: expected %08h, actual %08h", $time, want, got);
                errors++;
            end
        end
    endfunction

    function int pending();
        return pending_hashes.size();
    endfunction
endclass

module testbench;
    import cfsh_pkg::*;

    localparam int SETTLE_CYCLES  = 80;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 450;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_seed_we      = 1'b0;
    logic [31:0] i_seed_wdata   = 32'h0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_is_last      = 1'b0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [31:0] o_hash_value;

    hash_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;

    case_folding_string_hash dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_wdata   (i_seed_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hash_value   (o_hash_value)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= LONG_HOLD;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: feed accepted words to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_hash(o_hash_value);
            if (i_seed_we) sb.load_seed(i_seed_wdata);
            if (i_valid && !o_stall) sb.note_item(i_data_byte, i_byte_present, i_is_last);
        end
    end

    // Watchdog: ends the run after too long without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("%0t: watchdog expired", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one word, with random idle cycles first, and wait until it is taken
    task automatic send_item(input bit [7:0] value, input bit present, input bit is_end);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= value;
        i_byte_present <= present;
        i_is_last      <= is_end;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    // Stop offering, wait for all hashes, then let any mix in flight finish
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input bit [31:0] value);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= value;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
    endtask

    // Letters of both cases, or any byte
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'h41 + 8'($urandom_range(25));
            1:       return 8'h61 + 8'($urandom_range(25));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Random strings with some idle words mixed in
    task automatic run_strings(input int count);
        int  len;
        bit  separate_end;
        int  sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(19) == 0) send_item(pick_byte(), 1'b0, 1'b0);
            if ($urandom_range(9) == 0) len = $urandom_range(60, 25);
            else len = $urandom_range(24, 0);
            separate_end = (len == 0) || ($urandom_range(3) == 0);
            for (int i = 0; i < len; i++) begin
                send_item(pick_byte(), 1'b1, !separate_end && (i == len - 1));
                sent++;
            end
            if (separate_end) begin
                send_item(pick_byte(), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    initial begin : main
        bit [7:0] edge_bytes [12];
        sb = new();
        edge_bytes = '{8'h00, 8'hff, 8'h40, 8'h41, 8'h5a, 8'h5b,
                       8'h60, 8'h61, 8'h7a, 8'h7b, 8'h80, 8'hc0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty string with the reset seed, idle word, folding bounds
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'h41, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b1);
        // Twelve bytes with the last one completing a block
        foreach (edge_bytes[i]) send_item(edge_bytes[i], 1'b1, i == 11);
        settle();

        // Seed written mid-string: applies to the next string only
        send_item(8'h41, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h43, 1'b1, 1'b0);
        settle();
        write_seed(32'hffff_ffff);
        send_item(8'h7a, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        settle();

        // Zero seed, string closed by a separate terminator
        write_seed(32'h0000_0000);
        send_item(8'h58, 1'b1, 1'b0);
        send_item(8'h79, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        settle();

        // Sender idles lightly, receiver heavily
        write_seed($urandom);
        send_idle_pct  = 28;
        recv_stall_pct <= 64;
        run_strings(PHASE_ITEMS);
        settle();

        // Long receiver hold-off against a continuous sender
        write_seed($urandom);
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_asked     <= hold_asked + 1;
        run_strings(150);
        settle();

        // Roles swapped
        write_seed($urandom);
        send_idle_pct  = 64;
        recv_stall_pct <= 28;
        run_strings(PHASE_ITEMS);
        settle();

        // Full rate both ways
        write_seed($urandom);
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        run_strings(PHASE_ITEMS);
        settle();

        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
